@@ rtl/quaternion_to_euler_angles_defines.svh @@
// Assertion macros shared by the quaternion to Euler angle checker
`ifndef QUATERNION_TO_EULER_ANGLES_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_DEFINES_SVH

// Plain property, sampled on clk, off during reset
`define QTE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off during reset
`define QTE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/qte_pkg.sv @@
// Types, constants and helpers for the quaternion to Euler angle pipeline
package qte_pkg;

    // Output format and CORDIC depth
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int CORDIC_STAGES   = 16;
    localparam int CORDIC_ITERS    = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;

    // Internal angle unit is 2^-ZFRAC degree
    localparam int ZFRAC    = 24;
    localparam int ZW       = 36;
    localparam int ROUND_SH = ZFRAC - ANGLE_FRAC_BITS;

    // Datapath widths
    localparam int QIN_W  = 16;
    localparam int PROD_W = 32;
    localparam int IW     = 37;
    localparam int UV_W   = 34;
    localparam int HALF_W = 17;
    localparam int PP_W   = 2 * HALF_W;
    localparam int RW     = 66;
    localparam int QW     = RW / 2;
    localparam int RMW    = QW + 3;
    localparam int CW     = 44;
    localparam int NORM_TOP   = 40;
    localparam int MW         = NORM_TOP + 1;
    localparam int NORM_STEPS = 6;

    // Output widths
    localparam int ROLL_W  = 15;
    localparam int PITCH_W = 16;
    localparam int YAW_W   = 16;

    // Latencies
    localparam int PROD_LAT = 4;
    localparam int ATAN_LAT = 1 + NORM_STEPS + CORDIC_ITERS;
    localparam int PIPE_LAT = PROD_LAT + QW + ATAN_LAT + 2;

    // Angle constants
    localparam logic signed [ZW-1:0] DEG_180_Z = ZW'(longint'(180) << ZFRAC);
    localparam logic signed [ZW-1:0] DEG_360_Z = ZW'(longint'(360) << ZFRAC);
    localparam logic signed [ZW-1:0] ROLL_LIM_Z  = ZW'(longint'(90) << ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] PITCH_LIM_Z = ZW'(longint'(180) << ANGLE_FRAC_BITS);
    localparam logic signed [ZW-1:0] YAW_LIM_Z   = ZW'(longint'(360) << ANGLE_FRAC_BITS);

    // atan(2^-i) in units of 2^-24 degree
    localparam int ARCTAN_TAB [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // Input transaction
    typedef struct packed {
        logic signed [QIN_W-1:0] quat_a;
        logic signed [QIN_W-1:0] quat_b;
        logic signed [QIN_W-1:0] quat_c;
        logic signed [QIN_W-1:0] quat_d;
    } quat_in_t;

    // Result transaction
    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll_angle;
        logic signed [PITCH_W-1:0] pitch_angle;
        logic        [YAW_W-1:0]   yaw_angle;
        logic                      degenerate;
    } euler_out_t;

    // Values carried alongside the square root
    typedef struct packed {
        logic signed [IW-1:0] p_y;
        logic signed [IW-1:0] p_x;
        logic signed [IW-1:0] y_y;
        logic signed [IW-1:0] y_x;
        logic signed [IW-1:0] t;
        logic                 degen;
    } side_t;

    // Valid and zero flag riding next to the CORDIC lanes
    typedef struct packed {
        logic valid;
        logic degen;
    } ctl_t;

    // Signed 16x16 product
    function automatic logic signed [PROD_W-1:0] smul16(
        input logic signed [QIN_W-1:0] x,
        input logic signed [QIN_W-1:0] y
    );
        logic signed [PROD_W-1:0] xe;
        logic signed [PROD_W-1:0] ye;
        xe = PROD_W'(x);
        ye = PROD_W'(y);
        return xe * ye;
    endfunction

endpackage

@@ rtl/quaternion_to_euler_angles.sv @@
// Quaternion to Euler angle converter, top level
//
// Fully pipelined: a transaction is taken on every cycle that start is high, and
// busy never rises. The result appears with done after 4 product/sum stages,
// 33 square-root stages for the roll denominator, 23 CORDIC stages of quadrant
// fold, normalize and 16 iterations, then the remap and round registers.
// Results cannot be held off: done lasts one cycle and the angles are valid only
// then. An all-zero quaternion returns zero angles with degenerate set.
module quaternion_to_euler_angles (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  qte_pkg::quat_in_t     quat,
    output logic                  done,
    output qte_pkg::euler_out_t   angles
);
    import qte_pkg::*;

    function automatic logic signed [ZW-1:0] rnd_clamp(
        input logic signed [ZW-1:0] v,
        input logic signed [ZW-1:0] lo,
        input logic signed [ZW-1:0] hi
    );
        logic signed [ZW-1:0] r;
        r = (v + ZW'(longint'(1) << (ROUND_SH - 1))) >>> ROUND_SH;
        if (r < lo)
        begin
            r = lo;
        end
        if (r > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    logic                 pr_valid, sq_valid;
    side_t                pr_side, sq_side;
    logic [RW-1:0]        radicand;
    logic [QW-1:0]        root;
    logic signed [IW-1:0] roll_x;
    logic signed [ZW-1:0] z_pitch, z_yaw, z_roll;

    ctl_t                 ctl_reg [ATAN_LAT];
    ctl_t                 ctl_next;

    logic                 rm_valid_reg, rm_degen_reg;
    logic signed [ZW-1:0] roll_rm_reg, roll_rm_next;
    logic signed [ZW-1:0] pitch_rm_reg, pitch_rm_next;
    logic signed [ZW-1:0] yaw_rm_reg, yaw_rm_next;

    logic                 done_reg;
    euler_out_t           angles_reg, angles_next;

    assign busy = 1'b0;

    // Products, sums and radicand
    qte_prod u_prod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .quat      (quat),
        .out_valid (pr_valid),
        .side      (pr_side),
        .radicand  (radicand)
    );

    // Roll denominator sqrt((n-t)(n+t))
    qte_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pr_valid),
        .side_in   (pr_side),
        .radicand  (radicand),
        .out_valid (sq_valid),
        .side_out  (sq_side),
        .root      (root)
    );

    assign roll_x = $signed(IW'(root));

    // Three CORDIC lanes
    qte_atan2 u_atan_pitch (
        .clk   (clk),
        .y_in  (sq_side.p_y),
        .x_in  (sq_side.p_x),
        .z_out (z_pitch)
    );

    qte_atan2 u_atan_yaw (
        .clk   (clk),
        .y_in  (sq_side.y_y),
        .x_in  (sq_side.y_x),
        .z_out (z_yaw)
    );

    qte_atan2 u_atan_roll (
        .clk   (clk),
        .y_in  (sq_side.t),
        .x_in  (roll_x),
        .z_out (z_roll)
    );

    // Valid and zero flag alongside the CORDIC lanes
    assign ctl_next = '{valid: sq_valid, degen: sq_side.degen};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ATAN_LAT; i++)
            begin
                ctl_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < ATAN_LAT; i++)
            begin
                ctl_reg[i] <= ctl_reg[i-1];
            end
        end
    end

    // Remap angles to output conventions
    always_comb
    begin
        roll_rm_next  = -z_roll;
        pitch_rm_next = z_pitch[ZW-1] ? -(z_pitch + DEG_180_Z) : DEG_180_Z - z_pitch;
        yaw_rm_next   = z_yaw[ZW-1] ? -z_yaw : DEG_360_Z - z_yaw;
    end

    // Round, clamp and format the result
    always_comb
    begin
        logic signed [ZW-1:0] roll_r;
        logic signed [ZW-1:0] pitch_r;
        logic signed [ZW-1:0] yaw_r;
        roll_r  = rnd_clamp(roll_rm_reg, -ROLL_LIM_Z, ROLL_LIM_Z);
        pitch_r = rnd_clamp(pitch_rm_reg, -PITCH_LIM_Z, PITCH_LIM_Z);
        yaw_r   = rnd_clamp(yaw_rm_reg, '0, YAW_LIM_Z);
        if (rm_degen_reg)
        begin
            angles_next = '0;
            angles_next.degenerate = 1'b1;
        end
        else
        begin
            angles_next.roll_angle  = ROLL_W'(roll_r);
            angles_next.pitch_angle = PITCH_W'(pitch_r);
            angles_next.yaw_angle   = YAW_W'(yaw_r);
            angles_next.degenerate  = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rm_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rm_valid_reg <= ctl_reg[ATAN_LAT-1].valid;
            done_reg     <= rm_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rm_degen_reg <= ctl_reg[ATAN_LAT-1].degen;
        roll_rm_reg  <= roll_rm_next;
        pitch_rm_reg <= pitch_rm_next;
        yaw_rm_reg   <= yaw_rm_next;
        angles_reg   <= angles_next;
    end

    assign done   = done_reg;
    assign angles = angles_reg;

endmodule

@@ rtl/qte_prod.sv @@
// Component products, angle arguments and the (n-t)(n+t) radicand
module qte_prod (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  qte_pkg::quat_in_t        quat,
    output logic                     out_valid,
    output qte_pkg::side_t           side,
    output logic [qte_pkg::RW-1:0]   radicand
);
    import qte_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] aa, bb, cc, dd, bc, ad, ab, cd, bd, ac;
        logic                     degen;
    } prod_t;

    prod_t p_reg, p_next;
    side_t s2_reg, s2_next, s3_reg, s4_reg;
    logic [UV_W-1:0] u_reg, u_next, v_reg, v_next;
    logic [PP_W-1:0] hh_reg, hh_next, hl_reg, hl_next, lh_reg, lh_next, ll_reg, ll_next;
    logic [RW-1:0]   rad_reg, rad_next;
    logic [PROD_LAT-1:0] valid_reg;

    // Stage 1: ten products
    always_comb
    begin
        p_next.aa = smul16(quat.quat_a, quat.quat_a);
        p_next.bb = smul16(quat.quat_b, quat.quat_b);
        p_next.cc = smul16(quat.quat_c, quat.quat_c);
        p_next.dd = smul16(quat.quat_d, quat.quat_d);
        p_next.bc = smul16(quat.quat_b, quat.quat_c);
        p_next.ad = smul16(quat.quat_a, quat.quat_d);
        p_next.ab = smul16(quat.quat_a, quat.quat_b);
        p_next.cd = smul16(quat.quat_c, quat.quat_d);
        p_next.bd = smul16(quat.quat_b, quat.quat_d);
        p_next.ac = smul16(quat.quat_a, quat.quat_c);
        p_next.degen = (quat.quat_a == '0) && (quat.quat_b == '0) &&
                       (quat.quat_c == '0) && (quat.quat_d == '0);
    end

    // Stage 2: atan2 arguments, norm and asin numerator
    always_comb
    begin
        logic signed [IW-1:0] n_s;
        logic signed [IW-1:0] t_s;
        n_s = IW'(p_reg.aa) + IW'(p_reg.bb) + IW'(p_reg.cc) + IW'(p_reg.dd);
        t_s = (IW'(p_reg.bd) - IW'(p_reg.ac)) <<< 1;
        s2_next.p_y   = (IW'(p_reg.bc) + IW'(p_reg.ad)) <<< 1;
        s2_next.p_x   = IW'(p_reg.aa) + IW'(p_reg.bb) - IW'(p_reg.cc) - IW'(p_reg.dd);
        s2_next.y_y   = (IW'(p_reg.ab) + IW'(p_reg.cd)) <<< 1;
        s2_next.y_x   = IW'(p_reg.aa) - IW'(p_reg.bb) - IW'(p_reg.cc) + IW'(p_reg.dd);
        s2_next.t     = t_s;
        s2_next.degen = p_reg.degen;
        u_next = UV_W'(n_s - t_s);
        v_next = UV_W'(n_s + t_s);
    end

    // Stage 3: partial products of u*v
    always_comb
    begin
        hh_next = PP_W'(u_reg[UV_W-1:HALF_W]) * PP_W'(v_reg[UV_W-1:HALF_W]);
        hl_next = PP_W'(u_reg[UV_W-1:HALF_W]) * PP_W'(v_reg[HALF_W-1:0]);
        lh_next = PP_W'(u_reg[HALF_W-1:0]) * PP_W'(v_reg[UV_W-1:HALF_W]);
        ll_next = PP_W'(u_reg[HALF_W-1:0]) * PP_W'(v_reg[HALF_W-1:0]);
    end

    // Stage 4: combine partial products
    always_comb
    begin
        rad_next = (RW'(hh_reg) << (2 * HALF_W)) +
                   ((RW'(hl_reg) + RW'(lh_reg)) << HALF_W) + RW'(ll_reg);
    end

    // Valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PROD_LAT-2:0], in_valid};
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        s2_reg  <= s2_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        s3_reg  <= s2_reg;
        hh_reg  <= hh_next;
        hl_reg  <= hl_next;
        lh_reg  <= lh_next;
        ll_reg  <= ll_next;
        s4_reg  <= s3_reg;
        rad_reg <= rad_next;
    end

    assign out_valid = valid_reg[PROD_LAT-1];
    assign side      = s4_reg;
    assign radicand  = rad_reg;

endmodule

@@ rtl/qte_sqrt.sv @@
// Pipelined integer square root, one result bit per stage
module qte_sqrt (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  qte_pkg::side_t           side_in,
    input  logic [qte_pkg::RW-1:0]   radicand,
    output logic                     out_valid,
    output qte_pkg::side_t           side_out,
    output logic [qte_pkg::QW-1:0]   root
);
    import qte_pkg::*;

    logic            valid_reg [QW];
    logic [RW-1:0]   rad_reg   [QW];
    logic [RMW-1:0]  rem_reg   [QW];
    logic [QW-1:0]   root_reg  [QW];
    side_t           side_reg  [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic            valid_in;
        logic [RW-1:0]   rad_in;
        logic [RMW-1:0]  rem_in;
        logic [QW-1:0]   root_in;
        side_t           side_k;
        logic [RMW-1:0]  rem_try;
        logic [RMW-1:0]  test;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rad_in   = radicand;
            assign rem_in   = '0;
            assign root_in  = '0;
            assign side_k   = side_in;
        end
        else
        begin : g_next
            assign valid_in = valid_reg[k-1];
            assign rad_in   = rad_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign root_in  = root_reg[k-1];
            assign side_k   = side_reg[k-1];
        end

        // Bring down the next two radicand bits, try root*4+1
        assign rem_try = {rem_in[RMW-3:0], rad_in[RW-1 -: 2]};
        assign test    = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_in << 2;
            side_reg[k] <= side_k;
            if (rem_try >= test)
            begin
                rem_reg[k]  <= rem_try - test;
                root_reg[k] <= {root_in[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= rem_try;
                root_reg[k] <= {root_in[QW-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign side_out  = side_reg[QW-1];
    assign root      = root_reg[QW-1];

endmodule

@@ rtl/qte_atan2.sv @@
// Pipelined CORDIC atan2: quadrant fold, normalize, then vectoring iterations
module qte_atan2 (
    input  logic                            clk,
    input  logic signed [qte_pkg::IW-1:0]   y_in,
    input  logic signed [qte_pkg::IW-1:0]   x_in,
    output logic signed [qte_pkg::ZW-1:0]   z_out
);
    import qte_pkg::*;

    logic signed [CW-1:0] pre_x_reg, pre_x_next, pre_y_reg, pre_y_next;
    logic        [MW-1:0] pre_m_reg, pre_m_next;
    logic signed [ZW-1:0] pre_z_reg, pre_z_next;
    logic                 pre_zero_reg, pre_zero_next;

    logic signed [CW-1:0] nm_x_reg [NORM_STEPS];
    logic signed [CW-1:0] nm_y_reg [NORM_STEPS];
    logic        [MW-1:0] nm_m_reg [NORM_STEPS];
    logic signed [ZW-1:0] nm_z_reg [NORM_STEPS];
    logic                 nm_zero_reg [NORM_STEPS];

    logic signed [CW-1:0] it_x_reg [CORDIC_ITERS];
    logic signed [CW-1:0] it_y_reg [CORDIC_ITERS];
    logic signed [ZW-1:0] it_z_reg [CORDIC_ITERS];
    logic                 it_zero_reg [CORDIC_ITERS];

    // Fold the left half plane onto the right, find max magnitude
    always_comb
    begin
        logic signed [IW-1:0] ax;
        logic signed [IW-1:0] ay;
        logic                 xneg;
        xneg = x_in[IW-1];
        ax   = xneg ? -x_in : x_in;
        ay   = y_in[IW-1] ? -y_in : y_in;
        pre_x_next = CW'(ax);
        pre_y_next = xneg ? CW'(-y_in) : CW'(y_in);
        pre_m_next = (ax > ay) ? MW'(ax) : MW'(ay);
        if (!xneg)
        begin
            pre_z_next = '0;
        end
        else if (y_in[IW-1])
        begin
            pre_z_next = -DEG_180_Z;
        end
        else
        begin
            pre_z_next = DEG_180_Z;
        end
        pre_zero_next = (x_in == '0) && (y_in == '0);
    end

    always_ff @(posedge clk)
    begin
        pre_x_reg    <= pre_x_next;
        pre_y_reg    <= pre_y_next;
        pre_m_reg    <= pre_m_next;
        pre_z_reg    <= pre_z_next;
        pre_zero_reg <= pre_zero_next;
    end

    // Normalize so the larger magnitude sits in [2^40, 2^41)
    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic signed [CW-1:0] x_k, y_k;
        logic        [MW-1:0] m_k;
        logic signed [ZW-1:0] z_k;
        logic                 zero_k;
        logic                 do_sh;

        if (k == 0)
        begin : g_first
            assign x_k    = pre_x_reg;
            assign y_k    = pre_y_reg;
            assign m_k    = pre_m_reg;
            assign z_k    = pre_z_reg;
            assign zero_k = pre_zero_reg;
        end
        else
        begin : g_next
            assign x_k    = nm_x_reg[k-1];
            assign y_k    = nm_y_reg[k-1];
            assign m_k    = nm_m_reg[k-1];
            assign z_k    = nm_z_reg[k-1];
            assign zero_k = nm_zero_reg[k-1];
        end

        assign do_sh = (m_k[MW-1:NORM_TOP+1-SH] == '0);

        always_ff @(posedge clk)
        begin
            nm_x_reg[k]    <= do_sh ? (x_k <<< SH) : x_k;
            nm_y_reg[k]    <= do_sh ? (y_k <<< SH) : y_k;
            nm_m_reg[k]    <= do_sh ? (m_k << SH) : m_k;
            nm_z_reg[k]    <= z_k;
            nm_zero_reg[k] <= zero_k;
        end
    end

    // Vectoring iterations, one per stage
    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        logic signed [CW-1:0] x_i, y_i, xs, ys;
        logic signed [ZW-1:0] z_i;
        logic                 zero_i;

        if (i == 0)
        begin : g_first
            assign x_i    = nm_x_reg[NORM_STEPS-1];
            assign y_i    = nm_y_reg[NORM_STEPS-1];
            assign z_i    = nm_z_reg[NORM_STEPS-1];
            assign zero_i = nm_zero_reg[NORM_STEPS-1];
        end
        else
        begin : g_next
            assign x_i    = it_x_reg[i-1];
            assign y_i    = it_y_reg[i-1];
            assign z_i    = it_z_reg[i-1];
            assign zero_i = it_zero_reg[i-1];
        end

        assign xs = x_i >>> i;
        assign ys = y_i >>> i;

        always_ff @(posedge clk)
        begin
            it_zero_reg[i] <= zero_i;
            if (!y_i[CW-1])
            begin
                it_x_reg[i] <= x_i + ys;
                it_y_reg[i] <= y_i - xs;
                it_z_reg[i] <= z_i + ZW'(ARCTAN_TAB[i]);
            end
            else
            begin
                it_x_reg[i] <= x_i - ys;
                it_y_reg[i] <= y_i + xs;
                it_z_reg[i] <= z_i - ZW'(ARCTAN_TAB[i]);
            end
        end
    end

    // Both arguments zero gives a zero angle
    assign z_out = it_zero_reg[CORDIC_ITERS-1] ? '0 : it_z_reg[CORDIC_ITERS-1];

endmodule

@@ rtl/qte_checker.sv @@
// Port-level checker for the quaternion to Euler angle converter, with bind
`include "quaternion_to_euler_angles_defines.svh"

module qte_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input qte_pkg::euler_out_t   angles
);
    import qte_pkg::*;

    logic angles_zero;

    // All three angle fields at zero
    assign angles_zero = (angles.roll_angle == '0) && (angles.pitch_angle == '0) &&
                         (angles.yaw_angle == '0);

    // Never stalls the sender
    `QTE_ASSERT(a_never_busy, !busy, "busy raised")

    // Each result traces back to a transaction a fixed latency earlier
    `QTE_ASSERT_IMP(a_done_has_start, done, $past(start, PIPE_LAT), "done without start")

    // Each transaction produces its result after the fixed latency
    `QTE_ASSERT_IMP(a_start_gives_done, start, ##PIPE_LAT done, "start lost")

    // Zero quaternion returns zero angles
    `QTE_ASSERT_IMP(a_degen_zero, done && angles.degenerate, angles_zero, "degenerate nonzero")

    // Yaw stays within a full turn
    `QTE_ASSERT_IMP(a_yaw_range, done, angles.yaw_angle <= 16'd46080, "yaw out of range")

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);
